/* sv/ipv4fl_pkg.sv */
// Shared types, constants and helpers for the IPv4 forwarding lookup block.
// No dependencies.
package ipv4fl_pkg;

  localparam int unsigned ROUTES = 16;
  localparam int unsigned IDX_W  = (ROUTES > 1) ? $clog2(ROUTES) : 1;
  localparam int unsigned ADDR_W = 32;
  localparam int unsigned LEN_W  = 6;
  localparam int unsigned PORT_W = 2;
  localparam int unsigned NPORTS = 4;

  // verdict codes
  localparam logic [1:0] VERDICT_ROUTER   = 2'd0;
  localparam logic [1:0] VERDICT_FORWARD  = 2'd1;
  localparam logic [1:0] VERDICT_NO_ROUTE = 2'd2;
  localparam logic [1:0] VERDICT_WRITTEN  = 2'd3;

  // item modes
  localparam logic MODE_WRITE  = 1'b0;
  localparam logic MODE_LOOKUP = 1'b1;

  // one route table entry as seen by the scan
  typedef struct packed {
    logic [ADDR_W-1:0] network;
    logic [ADDR_W-1:0] netmask;
    logic [PORT_W-1:0] port;
    logic [LEN_W-1:0]  len;
    logic              valid;
  } entry_t;

  function automatic logic [3:0] ones8(input logic [7:0] v);
    logic [3:0] n;
    n = '0;
    for (int b = 0; b < 8; b++) begin
      n = n + {3'b000, v[b]};
    end
    return n;
  endfunction

  function automatic logic [LEN_W-1:0] ones32(input logic [ADDR_W-1:0] v);
    logic [LEN_W-1:0] s0;
    logic [LEN_W-1:0] s1;
    s0 = LEN_W'(ones8(v[7:0]))   + LEN_W'(ones8(v[15:8]));
    s1 = LEN_W'(ones8(v[23:16])) + LEN_W'(ones8(v[31:24]));
    return s0 + s1;
  endfunction

endpackage

/* sv/ipv4fl_table.sv */
// Route table storage: prefix, mask, port, mask length and valid bit per entry.
// Depends on ipv4fl_pkg. Mask length is counted once, at write time.
module ipv4fl_table (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             wr_en_i,
  input  logic [ipv4fl_pkg::IDX_W-1:0]     wr_idx_i,
  input  logic [ipv4fl_pkg::ADDR_W-1:0]    wr_network_i,
  input  logic [ipv4fl_pkg::ADDR_W-1:0]    wr_netmask_i,
  input  logic [ipv4fl_pkg::PORT_W-1:0]    wr_port_i,
  input  logic                             wr_valid_i,
  input  logic [ipv4fl_pkg::IDX_W-1:0]     rd_idx_i,
  output ipv4fl_pkg::entry_t               rd_entry_o
);

  logic [ipv4fl_pkg::ADDR_W-1:0] network_q [ipv4fl_pkg::ROUTES];
  logic [ipv4fl_pkg::ADDR_W-1:0] netmask_q [ipv4fl_pkg::ROUTES];
  logic [ipv4fl_pkg::PORT_W-1:0] port_q    [ipv4fl_pkg::ROUTES];
  logic [ipv4fl_pkg::LEN_W-1:0]  len_q     [ipv4fl_pkg::ROUTES];
  logic [ipv4fl_pkg::ROUTES-1:0] valid_q, valid_d;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      network_q[wr_idx_i] <= wr_network_i;
      netmask_q[wr_idx_i] <= wr_netmask_i;
      port_q[wr_idx_i]    <= wr_port_i;
      len_q[wr_idx_i]     <= ipv4fl_pkg::ones32(wr_netmask_i);
    end
  end

  always_comb begin
    valid_d = valid_q;
    if (wr_en_i) begin
      valid_d[wr_idx_i] = wr_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // entries never written stay invalid, so their payload is never used
  always_comb begin
    rd_entry_o.network = network_q[rd_idx_i];
    rd_entry_o.netmask = netmask_q[rd_idx_i];
    rd_entry_o.port    = port_q[rd_idx_i];
    rd_entry_o.len     = len_q[rd_idx_i];
    rd_entry_o.valid   = valid_q[rd_idx_i];
  end

endmodule

/* sv/ipv4_forwarding_lookup_top.sv */
// IPv4 forwarding lookup: interface address check, then longest-prefix scan.
// Depends on ipv4fl_pkg and ipv4fl_table.
//
//  channel   | handshake            | fields
//  ----------+----------------------+--------------------------------------------
//  item in   | start & !busy        | mode, entry_* (write), lookup_address
//  result    | done_o (1 cycle)     | verdict, chosen_port, match_length
//  config    | psel&penable&pwrite  | paddr[3:2] selects port0..3 address
//
// Write item: result strobe the cycle after accept, busy stays low.
// Lookup hitting an interface address: result the cycle after accept.
// Other lookups: one table entry per cycle through the compare unit, busy for
// the whole scan, result strobe in the cycle busy falls.
// Reset clears the config registers, the table valid bits and the sequencer.
// The result receiver cannot stall; each result word shows for one cycle.
module ipv4_forwarding_lookup_top (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // item channel
  input  logic                              start,
  output logic                              busy,
  input  logic                              mode_i,
  input  logic [3:0]                        entry_slot_i,
  input  logic [ipv4fl_pkg::ADDR_W-1:0]     entry_network_i,
  input  logic [ipv4fl_pkg::ADDR_W-1:0]     entry_netmask_i,
  input  logic [ipv4fl_pkg::PORT_W-1:0]     entry_port_i,
  input  logic                              entry_enable_i,
  input  logic [ipv4fl_pkg::ADDR_W-1:0]     lookup_address_i,
  // result channel
  output logic                              done_o,
  output logic [1:0]                        verdict_o,
  output logic [ipv4fl_pkg::PORT_W-1:0]     chosen_port_o,
  output logic [ipv4fl_pkg::LEN_W-1:0]      match_length_o,
  // config port
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [3:0]                        paddr,
  input  logic [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_SCAN = 2'b10
  } state_e;

  state_e state_q, state_d;

  logic [ipv4fl_pkg::ADDR_W-1:0] port_addr_q [ipv4fl_pkg::NPORTS];

  logic accept, wr_item, lk_item, slot_ok;
  logic own_hit;
  logic [ipv4fl_pkg::PORT_W-1:0] own_port;

  logic [ipv4fl_pkg::IDX_W-1:0]  idx_q, idx_d;
  logic [ipv4fl_pkg::ADDR_W-1:0] dst_q, dst_d;
  logic                          found_q, found_d;
  logic [ipv4fl_pkg::LEN_W-1:0]  best_len_q, best_len_d;
  logic [ipv4fl_pkg::PORT_W-1:0] best_port_q, best_port_d;

  logic                          done_q, done_d;
  logic [1:0]                    verdict_q, verdict_d;
  logic [ipv4fl_pkg::PORT_W-1:0] cport_q, cport_d;
  logic [ipv4fl_pkg::LEN_W-1:0]  mlen_q, mlen_d;

  ipv4fl_pkg::entry_t entry;
  logic hit, better;

  // ---------------- config registers ----------------
  assign pready = 1'b1;
  assign prdata = port_addr_q[paddr[3:2]];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int p = 0; p < ipv4fl_pkg::NPORTS; p++) begin
        port_addr_q[p] <= '0;
      end
    end else if (psel && penable && pwrite && pready) begin
      port_addr_q[paddr[3:2]] <= pwdata;
    end
  end

  // ---------------- item intake ----------------
  assign busy    = (state_q != ST_IDLE);
  assign accept  = start && !busy;
  assign wr_item = accept && (mode_i == ipv4fl_pkg::MODE_WRITE);
  assign lk_item = accept && (mode_i == ipv4fl_pkg::MODE_LOOKUP);
  assign slot_ok = (32'(entry_slot_i) < 32'(ipv4fl_pkg::ROUTES));

  // lowest-numbered interface wins
  always_comb begin
    own_hit  = 1'b0;
    own_port = '0;
    for (int p = ipv4fl_pkg::NPORTS - 1; p >= 0; p--) begin
      if (port_addr_q[p] == lookup_address_i) begin
        own_hit  = 1'b1;
        own_port = ipv4fl_pkg::PORT_W'(p);
      end
    end
  end

  ipv4fl_table u_table (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .wr_en_i      (wr_item && slot_ok),
    .wr_idx_i     (ipv4fl_pkg::IDX_W'(entry_slot_i)),
    .wr_network_i (entry_network_i),
    .wr_netmask_i (entry_netmask_i),
    .wr_port_i    (entry_port_i),
    .wr_valid_i   (entry_enable_i),
    .rd_idx_i     (idx_q),
    .rd_entry_o   (entry)
  );

  // ---------------- shared compare unit ----------------
  assign hit    = entry.valid &&
                  ((dst_q & entry.netmask) == (entry.network & entry.netmask));
  // strict greater keeps the lowest index on a tie
  assign better = hit && (!found_q || (entry.len > best_len_q));

  // ---------------- sequencer ----------------
  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    dst_d       = dst_q;
    found_d     = found_q;
    best_len_d  = best_len_q;
    best_port_d = best_port_q;
    done_d      = 1'b0;
    verdict_d   = verdict_q;
    cport_d     = cport_q;
    mlen_d      = mlen_q;

    unique case (state_q)
      ST_IDLE: begin
        if (wr_item) begin
          done_d    = 1'b1;
          verdict_d = ipv4fl_pkg::VERDICT_WRITTEN;
          cport_d   = '0;
          mlen_d    = '0;
        end else if (lk_item && own_hit) begin
          done_d    = 1'b1;
          verdict_d = ipv4fl_pkg::VERDICT_ROUTER;
          cport_d   = own_port;
          mlen_d    = '0;
        end else if (lk_item) begin
          state_d    = ST_SCAN;
          idx_d      = '0;
          dst_d      = lookup_address_i;
          found_d    = 1'b0;
          best_len_d = '0;
          best_port_d = '0;
        end
      end
      ST_SCAN: begin
        if (better) begin
          found_d     = 1'b1;
          best_len_d  = entry.len;
          best_port_d = entry.port;
        end
        if (32'(idx_q) == 32'(ipv4fl_pkg::ROUTES - 1)) begin
          state_d = ST_IDLE;
          done_d  = 1'b1;
          if (found_d) begin
            verdict_d = ipv4fl_pkg::VERDICT_FORWARD;
            cport_d   = best_port_d;
            mlen_d    = best_len_d;
          end else begin
            verdict_d = ipv4fl_pkg::VERDICT_NO_ROUTE;
            cport_d   = '0;
            mlen_d    = '0;
          end
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      idx_q   <= '0;
      found_q <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      found_q <= found_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dst_q       <= dst_d;
    best_len_q  <= best_len_d;
    best_port_q <= best_port_d;
    verdict_q   <= verdict_d;
    cport_q     <= cport_d;
    mlen_q      <= mlen_d;
  end

  assign done_o         = done_q;
  assign verdict_o      = verdict_q;
  assign chosen_port_o  = cport_q;
  assign match_length_o = mlen_q;

  // ---------------- assertions ----------------
  a_done_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result strobe while sequencer busy");

  a_accept_answered : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (done_o || busy))
    else $error("accepted word neither answered nor in progress");

  a_scan_start : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (lk_item && !own_hit) |=> (busy && !done_o && (idx_q == '0)))
    else $error("lookup did not start the table scan");

  a_len_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (verdict_o != ipv4fl_pkg::VERDICT_FORWARD)) |-> (match_length_o == '0))
    else $error("match length set without a forward verdict");

  a_len_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (match_length_o <= 6'd32))
    else $error("match length beyond address width");

endmodule

/* bench/tb.sv */
// Self-checking bench for ipv4_forwarding_lookup_top: directed and random route words,
// predicted in-bench and compared per field. Depends on ipv4fl_pkg and the block RTL.
module tb;
  import ipv4fl_pkg::*;

  localparam int unsigned REG_PORT0 = 0;   // port0..port3 address registers follow
  localparam int unsigned ITEMS_PER_PHASE = 325;

  typedef struct packed {
    logic              mode;
    logic [3:0]        slot;
    logic [ADDR_W-1:0] network;
    logic [ADDR_W-1:0] netmask;
    logic [PORT_W-1:0] port;
    logic              enable;
    logic [ADDR_W-1:0] dst;
  } route_word_t;

  typedef struct packed {
    logic [1:0]        verdict;
    logic [PORT_W-1:0] port;
    logic [LEN_W-1:0]  length;
  } decision_t;

  logic              clk_i;
  logic              rst_ni;
  logic              start;
  logic              busy;
  logic              mode_i;
  logic [3:0]        entry_slot_i;
  logic [ADDR_W-1:0] entry_network_i;
  logic [ADDR_W-1:0] entry_netmask_i;
  logic [PORT_W-1:0] entry_port_i;
  logic              entry_enable_i;
  logic [ADDR_W-1:0] lookup_address_i;
  logic              done_o;
  logic [1:0]        verdict_o;
  logic [PORT_W-1:0] chosen_port_o;
  logic [LEN_W-1:0]  match_length_o;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [3:0]        paddr;
  logic [31:0]       pwdata;
  logic [31:0]       prdata;
  logic              pready;

  // bench copy of the block state
  logic [ADDR_W-1:0] own_addr [NPORTS];
  logic [ADDR_W-1:0] rt_net   [ROUTES];
  logic [ADDR_W-1:0] rt_mask  [ROUTES];
  logic [PORT_W-1:0] rt_port  [ROUTES];
  logic              rt_valid [ROUTES];

  decision_t pending_verdicts[$];
  int unsigned mismatch_count = 0;
  bit idle_on = 1'b1;

  ipv4_forwarding_lookup_top u_top (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start            (start),
    .busy             (busy),
    .mode_i           (mode_i),
    .entry_slot_i     (entry_slot_i),
    .entry_network_i  (entry_network_i),
    .entry_netmask_i  (entry_netmask_i),
    .entry_port_i     (entry_port_i),
    .entry_enable_i   (entry_enable_i),
    .lookup_address_i (lookup_address_i),
    .done_o           (done_o),
    .verdict_o        (verdict_o),
    .chosen_port_o    (chosen_port_o),
    .match_length_o   (match_length_o),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #4000000;
    $display("Mismatches found");
    $finish;
  end

  function automatic int unsigned mask_ones(input logic [ADDR_W-1:0] m);
    int unsigned n;
    n = 0;
    for (int b = 0; b < ADDR_W; b++) begin
      if (m[b]) n++;
    end
    return n;
  endfunction

  // Applies a word to the bench state and returns the decision the block owes for it.
  function automatic decision_t forward_decision(input route_word_t w);
    decision_t d;
    bit found;
    int unsigned best;
    int unsigned n;
    d.verdict = VERDICT_WRITTEN;
    d.port = '0;
    d.length = '0;
    found = 1'b0;
    best = 0;
    if (w.mode == MODE_WRITE) begin
      if (w.slot < ROUTES) begin
        rt_net[w.slot]   = w.network;
        rt_mask[w.slot]  = w.netmask;
        rt_port[w.slot]  = w.port;
        rt_valid[w.slot] = w.enable;
      end
    end else begin
      // descending scan so the lowest matching interface wins
      for (int p = NPORTS - 1; p >= 0; p--) begin
        if (own_addr[p] == w.dst) begin
          d.verdict = VERDICT_ROUTER;
          d.port = PORT_W'(p);
        end
      end
      if (d.verdict != VERDICT_ROUTER) begin
        for (int i = 0; i < ROUTES; i++) begin
          if (rt_valid[i] && ((w.dst & rt_mask[i]) == (rt_net[i] & rt_mask[i]))) begin
            n = mask_ones(rt_mask[i]);
            if (!found || n > best) begin
              found = 1'b1;
              best = n;
              d.port = rt_port[i];
            end
          end
        end
        if (found) begin
          d.verdict = VERDICT_FORWARD;
          d.length = LEN_W'(best);
        end else begin
          d.verdict = VERDICT_NO_ROUTE;
          d.port = '0;
        end
      end
    end
    return d;
  endfunction

  function automatic route_word_t route_write(input logic [3:0] slot,
                                              input logic [ADDR_W-1:0] net,
                                              input logic [ADDR_W-1:0] mask,
                                              input logic [PORT_W-1:0] port,
                                              input logic en);
    route_word_t w;
    w.mode = MODE_WRITE;
    w.slot = slot;
    w.network = net;
    w.netmask = mask;
    w.port = port;
    w.enable = en;
    w.dst = $urandom;
    return w;
  endfunction

  function automatic route_word_t route_lookup(input logic [ADDR_W-1:0] dst);
    route_word_t w;
    w = route_write(4'($urandom), $urandom, $urandom, PORT_W'($urandom), 1'($urandom));
    w.mode = MODE_LOOKUP;
    w.dst = dst;
    return w;
  endfunction

  // Mostly prefix masks and addresses aimed at live entries or own interfaces.
  function automatic route_word_t random_word();
    route_word_t w;
    int unsigned plen;
    int unsigned pick;
    int unsigned s;
    w.mode = ($urandom_range(0, 99) < 25) ? MODE_WRITE : MODE_LOOKUP;
    w.slot = 4'($urandom);
    w.network = $urandom;
    w.port = PORT_W'($urandom);
    w.enable = ($urandom_range(0, 99) < 85);
    plen = $urandom_range(0, ADDR_W);
    if ($urandom_range(0, 9) < 8)
      w.netmask = (plen == 0) ? '0 : ({ADDR_W{1'b1}} << (ADDR_W - plen));
    else
      w.netmask = $urandom;
    pick = $urandom_range(0, 99);
    s = $urandom_range(0, ROUTES - 1);
    w.dst = $urandom;
    if (pick < 15)
      w.dst = own_addr[$urandom_range(0, NPORTS - 1)];
    else if (pick < 75 && rt_valid[s])
      w.dst = (rt_net[s] & rt_mask[s]) | (w.dst & ~rt_mask[s]);
    return w;
  endfunction

  // Called at a rising edge; returns at the edge that accepted the word.
  task automatic issue_word(input route_word_t w);
    int unsigned gap;
    gap = idle_on ? $urandom_range(0, 16) : 0;
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start            <= 1'b1;
    mode_i           <= w.mode;
    entry_slot_i     <= w.slot;
    entry_network_i  <= w.network;
    entry_netmask_i  <= w.netmask;
    entry_port_i     <= w.port;
    entry_enable_i   <= w.enable;
    lookup_address_i <= w.dst;
    do @(posedge clk_i); while (busy);
    pending_verdicts.push_back(forward_decision(w));
  endtask

  task automatic wait_idle();
    start <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk_i);
    repeat (ROUTES + 2) @(posedge clk_i);
  endtask

  // APB write followed by a read-back of the same register
  task automatic write_port_address(input int unsigned p, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= 4'((REG_PORT0 + p) * 4);
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    own_addr[p] = value;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    psel    <= 1'b1;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== value) begin
      $error("prdata: expected %h, actual %h", value, prdata);
      mismatch_count++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic test_reset_state();
    // all interfaces still zero: lowest one reported; empty table gives no route
    issue_word(route_lookup('0));
    issue_word(route_lookup(32'hC0A8_0001));
    issue_word(route_lookup(32'hFFFF_FFFF));
  endtask

  task automatic test_directed_routes();
    wait_idle();
    write_port_address(0, 32'h0A00_0001);
    write_port_address(1, 32'hC0A8_0101);
    write_port_address(2, 32'hFFFF_FFFF);
    write_port_address(3, 32'hC0A8_0101);  // same as port1
    // default route with a nonzero network under a zero mask
    issue_word(route_write(4'd0, 32'hDEAD_BEEF, 32'h0000_0000, 2'd3, 1'b1));
    issue_word(route_write(4'd1, 32'h0A00_0000, 32'hFF00_0000, 2'd1, 1'b1));
    issue_word(route_write(4'd2, 32'h0A01_0000, 32'hFFFF_0000, 2'd2, 1'b1));
    issue_word(route_write(4'd15, 32'h0A01_0200, 32'hFFFF_FF00, 2'd0, 1'b1));
    issue_word(route_write(4'd3, 32'h0A00_0000, 32'hFF00_0000, 2'd2, 1'b1));  // tie with slot 1
    issue_word(route_write(4'd4, 32'h0A00_0300, 32'hFF00_FF00, 2'd3, 1'b1));  // holes in mask
    issue_word(route_write(4'd5, 32'hFFFF_FFFE, 32'hFFFF_FFFF, 2'd2, 1'b1));
    issue_word(route_write(4'd6, 32'h0A01_0203, 32'hFFFF_FFFF, 2'd1, 1'b0));  // never valid
    issue_word(route_lookup(32'h0A01_0203));
    issue_word(route_lookup(32'h0A01_0909));
    issue_word(route_lookup(32'h0A09_0909));
    issue_word(route_lookup(32'h0808_0808));
    issue_word(route_lookup(32'hFFFF_FFFF));
    issue_word(route_lookup(32'hC0A8_0101));
    issue_word(route_lookup(32'h0A00_0001));
    issue_word(route_lookup(32'h0A7F_03FF));
    issue_word(route_lookup(32'hFFFF_FFFE));
    // drop the default route, then an unmatched address has nowhere to go
    issue_word(route_write(4'd0, 32'h0000_0000, 32'h0000_0000, 2'd0, 1'b0));
    issue_word(route_lookup(32'h0808_0808));
    issue_word(route_lookup(32'h0000_0000));
  endtask

  task automatic test_random_traffic();
    logic [31:0] same;
    for (int ph = 0; ph < 5; ph++) begin
      wait_idle();
      same = $urandom;
      for (int p = 0; p < NPORTS; p++) begin
        case (ph)
          0: write_port_address(p, 32'hFFFF_FFFF);
          2: write_port_address(p, same);
          3: write_port_address(p, 32'h0000_0000);
          default: write_port_address(p, $urandom);
        endcase
      end
      for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
        if (k % 40 == 0) idle_on = ($urandom_range(0, 3) != 0);
        issue_word(random_word());
      end
      idle_on = 1'b1;
    end
  endtask

  always @(posedge clk_i) begin
    decision_t want;
    if (rst_ni && done_o) begin
      if (pending_verdicts.size() == 0) begin
        $error("unexpected result word: verdict %0d", verdict_o);
        mismatch_count++;
      end else begin
        want = pending_verdicts.pop_front();
        if (verdict_o !== want.verdict) begin
          $error("verdict: expected %0d, actual %0d", want.verdict, verdict_o);
          mismatch_count++;
        end
        if (chosen_port_o !== want.port) begin
          $error("chosen_port: expected %0d, actual %0d", want.port, chosen_port_o);
          mismatch_count++;
        end
        if (match_length_o !== want.length) begin
          $error("match_length: expected %0d, actual %0d", want.length, match_length_o);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    for (int p = 0; p < NPORTS; p++) own_addr[p] = '0;
    for (int i = 0; i < ROUTES; i++) begin
      rt_net[i]   = '0;
      rt_mask[i]  = '0;
      rt_port[i]  = '0;
      rt_valid[i] = 1'b0;
    end
    rst_ni           <= 1'b0;
    start            <= 1'b0;
    mode_i           <= MODE_WRITE;
    entry_slot_i     <= '0;
    entry_network_i  <= '0;
    entry_netmask_i  <= '0;
    entry_port_i     <= '0;
    entry_enable_i   <= 1'b0;
    lookup_address_i <= '0;
    psel             <= 1'b0;
    penable          <= 1'b0;
    pwrite           <= 1'b0;
    paddr            <= '0;
    pwdata           <= '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_reset_state();
    test_directed_routes();
    test_random_traffic();
    wait_idle();
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

/* filelist.f */
sv/ipv4fl_pkg.sv
sv/ipv4fl_table.sv
sv/ipv4_forwarding_lookup_top.sv
bench/tb.sv
